[rtl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the rate limited round robin tx scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int NODE_COUNT  = 4;
	localparam int FRAME_SLOTS = 8;
	localparam int NODE_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
	localparam int MEM_DEPTH   = NODE_COUNT * FRAME_SLOTS;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int SCAN_W      = $clog2(NODE_COUNT + 1);
	localparam int HDR_W       = 15;
	localparam logic [3:0] MAX_LEN  = 4'd8;
	localparam logic [3:0] SENT_MOD = 4'd10;

	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_ENQUEUE = 3'd1,
		KIND_SEND    = 3'd2,
		KIND_BUS_ERR = 3'd3,
		KIND_BUS_RST = 3'd4,
		KIND_TIMEOUT = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_OVERRUN = 3'd1,
		ERR_REFUSED = 3'd2,
		ERR_BUS     = 3'd3,
		ERR_TIMEOUT = 3'd4
	} err_t;

	localparam logic [2:0] CFG_TIMEOUT = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_POP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_start;
		logic scan_step;
		logic pop;
		logic result;
	} cmd_t;

	typedef struct packed {
		logic is_send;
		logic scan_hit;
		logic scan_done;
	} sts_t;

endpackage

[rtl/rrts_datapath.sv]
// ----------------------------------------------------------------------------
// rrts_datapath
// Queues, frame memories, timers, round robin scan and result register.
// ----------------------------------------------------------------------------
module rrts_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [31:0]                cfg_data,
	input  logic [87:0]                in_data,
	input  logic [1:0]                 in_user,
	input  rrts_pkg::cmd_t             cmd,
	output rrts_pkg::sts_t             sts,
	output logic [95:0]                out_data
);

	logic [2:0]  kind_q;
	logic [1:0]  idx_q;
	logic [10:0] id_q;
	logic [3:0]  len_q;
	logic [63:0] pay_q;
	logic        mbox_q;
	logic        acc_q;

	logic [15:0] min_period_q [rrts_pkg::NODE_COUNT];
	logic [31:0] timeout_q;
	logic [rrts_pkg::SLOT_W-1:0] head_q [rrts_pkg::NODE_COUNT];
	logic [rrts_pkg::CNT_W-1:0]  count_q [rrts_pkg::NODE_COUNT];
	logic [31:0] last_q [rrts_pkg::NODE_COUNT];
	logic [2:0]  err_q [rrts_pkg::NODE_COUNT];
	logic [rrts_pkg::NODE_W-1:0] next_q;
	logic [31:0] now_q;
	logic [3:0]  sent_q;

	logic [rrts_pkg::NODE_W-1:0] scan_node_q;
	logic [rrts_pkg::SCAN_W-1:0] scan_cnt_q;
	logic        picked_q;
	logic [rrts_pkg::NODE_W-1:0] rep_q;

	logic [rrts_pkg::HDR_W-1:0] hdr_mem [rrts_pkg::MEM_DEPTH];
	logic [63:0] pay_mem [rrts_pkg::MEM_DEPTH];
	logic [rrts_pkg::HDR_W-1:0] hdr_rd_q;
	logic [63:0] pay_rd_q;

	logic [85:0] out_q;

	logic [3:0]  len_sat;
	logic [63:0] len_mask;
	logic        idx_ok;
	logic [rrts_pkg::NODE_W-1:0] idx_n;
	logic [rrts_pkg::NODE_W-1:0] scan_next;
	logic        eligible;
	logic [31:0] since_scan;
	logic [31:0] since_idx;
	logic [rrts_pkg::SLOT_W:0] tail_sum;
	logic [rrts_pkg::SLOT_W-1:0] tail;
	logic [rrts_pkg::SLOT_W-1:0] head_inc;
	logic [rrts_pkg::ADDR_W-1:0] wr_addr;
	logic [rrts_pkg::ADDR_W-1:0] rd_addr;
	logic        do_write;

	assign idx_ok = ({30'd0, idx_q} < 32'(rrts_pkg::NODE_COUNT));
	assign idx_n  = rrts_pkg::NODE_W'(idx_q);
	assign len_sat = (len_q > rrts_pkg::MAX_LEN) ? rrts_pkg::MAX_LEN : len_q;
	always_comb begin
		for (int b = 0; b < 8; b++)
			len_mask[b*8 +: 8] = (4'(b) < len_sat) ? 8'hff : 8'h00;
	end

	assign scan_next = (32'(scan_node_q) + 1 >= rrts_pkg::NODE_COUNT) ?
		'0 : scan_node_q + 1'b1;
	assign since_scan = now_q - last_q[scan_node_q];
	assign since_idx  = now_q - last_q[idx_n];
	assign eligible = (count_q[scan_node_q] != '0) &&
		(since_scan > {16'd0, min_period_q[scan_node_q]});

	assign tail_sum = {1'b0, head_q[idx_n]} + rrts_pkg::SLOT_W'(count_q[idx_n]);
	assign tail = (32'(tail_sum) >= rrts_pkg::FRAME_SLOTS) ?
		rrts_pkg::SLOT_W'(32'(tail_sum) - rrts_pkg::FRAME_SLOTS) :
		rrts_pkg::SLOT_W'(tail_sum);
	assign head_inc = (32'(head_q[scan_node_q]) + 1 >= rrts_pkg::FRAME_SLOTS) ?
		'0 : head_q[scan_node_q] + 1'b1;
	assign wr_addr = rrts_pkg::ADDR_W'(32'(idx_n) * rrts_pkg::FRAME_SLOTS + 32'(tail));
	assign rd_addr = rrts_pkg::ADDR_W'(32'(scan_node_q) * rrts_pkg::FRAME_SLOTS
		+ 32'(head_q[scan_node_q]));

	assign do_write = cmd.exec && kind_q == rrts_pkg::KIND_ENQUEUE && idx_ok &&
		err_q[idx_n] == rrts_pkg::ERR_NONE &&
		32'(count_q[idx_n]) < rrts_pkg::FRAME_SLOTS;

	always_ff @(posedge clk) begin
		if (do_write) begin
			hdr_mem[wr_addr] <= {len_sat, id_q};
			pay_mem[wr_addr] <= pay_q & len_mask;
		end
		hdr_rd_q <= hdr_mem[rd_addr];
		pay_rd_q <= pay_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_data[2:0];
			idx_q  <= in_data[4:3];
			id_q   <= in_data[15:5];
			len_q  <= in_data[19:16];
			pay_q  <= in_data[83:20];
			mbox_q <= in_user[0];
			acc_q  <= in_user[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < rrts_pkg::NODE_COUNT; n++) begin
				min_period_q[n] <= '0;
				head_q[n] <= '0;
				count_q[n] <= '0;
				last_q[n] <= '0;
				err_q[n] <= rrts_pkg::ERR_NONE;
			end
			timeout_q <= 32'd1000;
			next_q <= '0;
			now_q <= '0;
			sent_q <= '0;
			scan_node_q <= '0;
			scan_cnt_q <= '0;
			picked_q <= 1'b0;
			rep_q <= '0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				if (32'(cfg_index) < rrts_pkg::NODE_COUNT && cfg_index < rrts_pkg::CFG_TIMEOUT)
					min_period_q[rrts_pkg::NODE_W'(cfg_index)] <= cfg_data[15:0];
				else if (cfg_index == rrts_pkg::CFG_TIMEOUT)
					timeout_q <= cfg_data;
			end
			if (cmd.exec) begin
				picked_q <= 1'b0;
				rep_q <= idx_n;
				case (kind_q)
					rrts_pkg::KIND_TICK: now_q <= now_q + 32'd1;
					rrts_pkg::KIND_ENQUEUE: begin
						if (idx_ok && err_q[idx_n] == rrts_pkg::ERR_NONE) begin
							if (32'(count_q[idx_n]) >= rrts_pkg::FRAME_SLOTS)
								err_q[idx_n] <= rrts_pkg::ERR_OVERRUN;
							else
								count_q[idx_n] <= count_q[idx_n] + 1'b1;
						end
					end
					rrts_pkg::KIND_BUS_ERR:
						for (int n = 0; n < rrts_pkg::NODE_COUNT; n++)
							err_q[n] <= rrts_pkg::ERR_BUS;
					rrts_pkg::KIND_BUS_RST:
						for (int n = 0; n < rrts_pkg::NODE_COUNT; n++) begin
							err_q[n] <= rrts_pkg::ERR_NONE;
							head_q[n] <= '0;
							count_q[n] <= '0;
						end
					rrts_pkg::KIND_TIMEOUT:
						if (idx_ok && count_q[idx_n] != '0 && since_idx > timeout_q)
							err_q[idx_n] <= rrts_pkg::ERR_TIMEOUT;
					default: ;
				endcase
			end
			if (cmd.scan_start) begin
				scan_node_q <= next_q;
				scan_cnt_q <= '0;
			end
			if (cmd.scan_step) begin
				scan_node_q <= scan_next;
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (cmd.pop) begin
				picked_q <= 1'b1;
				rep_q <= scan_node_q;
				last_q[scan_node_q] <= now_q;
				head_q[scan_node_q] <= head_inc;
				count_q[scan_node_q] <= count_q[scan_node_q] - 1'b1;
				if (acc_q) begin
					sent_q <= (sent_q + 4'd1 >= rrts_pkg::SENT_MOD) ? 4'd0 : sent_q + 4'd1;
					next_q <= scan_next;
				end else begin
					err_q[scan_node_q] <= rrts_pkg::ERR_REFUSED;
				end
			end
			if (cmd.result) begin
				if (picked_q && acc_q)
					out_q[81:0] <= {pay_rd_q, hdr_rd_q[14:11], hdr_rd_q[10:0],
						2'(rep_q), 1'b1};
				else
					out_q[81:0] <= '0;
				if (picked_q || idx_ok) begin
					out_q[84:82] <= err_q[rep_q];
					out_q[85] <= (count_q[rep_q] == '0);
				end else begin
					out_q[84:82] <= rrts_pkg::ERR_NONE;
					out_q[85] <= 1'b1;
				end
			end
		end
	end

	assign sts.is_send   = (kind_q == rrts_pkg::KIND_SEND) && mbox_q;
	assign sts.scan_hit  = eligible;
	assign sts.scan_done = (32'(scan_cnt_q) >= rrts_pkg::NODE_COUNT);
	assign out_data = {6'd0, sent_q, out_q};

	always_ff @(posedge clk) begin
		if (cmd.pop && 32'(count_q[scan_node_q]) == 0)
			$error("pop from empty queue");
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> picked_q)
		else $error("pop not recorded");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(scan_cnt_q) <= rrts_pkg::NODE_COUNT)
		else $error("scan overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		sent_q < rrts_pkg::SENT_MOD)
		else $error("sent count out of range");

endmodule

[rtl/rrts_ctrl.sv]
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: accept a word, run it, scan nodes, pop, present the result.
// ----------------------------------------------------------------------------
module rrts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           out_fire,
	input  rrts_pkg::sts_t sts,
	output rrts_pkg::cmd_t cmd,
	output logic           in_ready,
	output logic           out_valid
);

	rrts_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rrts_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			rrts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = rrts_pkg::ST_SCAN;
				end
			end
			rrts_pkg::ST_SCAN: begin
				cmd.exec = 1'b1;
				cmd.scan_start = 1'b1;
				state_d = sts.is_send ? rrts_pkg::ST_READ : rrts_pkg::ST_POP;
			end
			rrts_pkg::ST_READ: begin
				if (sts.scan_done) begin
					cmd.result = 1'b1;
					state_d = rrts_pkg::ST_OUT;
				end else if (sts.scan_hit) begin
					state_d = rrts_pkg::ST_POP;
					cmd.pop = 1'b1;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			rrts_pkg::ST_POP: begin
				cmd.result = 1'b1;
				state_d = rrts_pkg::ST_OUT;
			end
			rrts_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_fire)
					state_d = rrts_pkg::ST_IDLE;
			end
			default: state_d = rrts_pkg::ST_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while holding result");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> cmd.exec)
		else $error("accepted word not executed");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |=> out_valid)
		else $error("result not presented");

endmodule

[rtl/rate_limited_round_robin_tx_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// rate_limited_round_robin_tx_scheduler_unit
// Per node frame queues served round robin under a minimum send period.
// ----------------------------------------------------------------------------
// Usage: each input word (s_axis) carries kind, node_index, can_id, length
// and payload in tdata and mailbox_free, controller_accepts in tuser. Each
// word gives exactly one result word on m_axis.
// A non-send word passes the SCAN and POP states before its result is valid;
// a send opportunity passes SCAN, then READ for the eligibility scan, which
// checks one node per cycle, and on a hit POP for the registered frame read.
// The unit takes one word at a time; the next word is taken only once the
// result has been taken and the sequencer is back in its idle state.
// When the receiver stalls, the result holds in the output register and
// s_axis_tready stays low.
// Reset clears queues, errors, times, the round robin pointer, the sent
// count and the registers (timeout 1000); frame memories keep old data.
// Configuration: cfg_we with cfg_index 0..3 sets min periods, 4 the timeout.
// ----------------------------------------------------------------------------
module rate_limited_round_robin_tx_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// kind, node_index, can_id, length, payload, zero fill
	input  logic [87:0] s_axis_tdata,
	// mailbox_free, controller_accepts
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// frame_valid, frame_node, frame_can_id, frame_length, frame_payload,
	// node_status, queue_empty, sent_count, zero fill
	output logic [95:0] m_axis_tdata
);

	rrts_pkg::cmd_t cmd;
	rrts_pkg::sts_t sts;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (s_axis_tvalid && s_axis_tready),
		.out_fire  (m_axis_tvalid && m_axis_tready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid)
	);

	rrts_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata)
	);

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the round robin transmit scheduler: directed and
// random words, per-word prediction of the result word, field-wise checks,
// random stalls on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit        valid;
		bit [1:0]  node;
		bit [10:0] can_id;
		bit [3:0]  len;
		bit [63:0] payload;
		bit [2:0]  status;
		bit        empty;
		bit [3:0]  sent;
	} tx_result_t;

	class tx_scoreboard;
		bit [10:0]       slot_id[rrts_pkg::MEM_DEPTH];
		bit [3:0]        slot_len[rrts_pkg::MEM_DEPTH];
		bit [63:0]       slot_pay[rrts_pkg::MEM_DEPTH];
		int unsigned     head[rrts_pkg::NODE_COUNT];
		int unsigned     count[rrts_pkg::NODE_COUNT];
		bit [31:0]       last_sent[rrts_pkg::NODE_COUNT];
		rrts_pkg::err_t  err[rrts_pkg::NODE_COUNT];
		bit [15:0]       period[rrts_pkg::NODE_COUNT];
		bit [31:0]       pend_limit;
		bit [31:0]       ticks;
		int unsigned     rr_ptr;
		int unsigned     sent_mod;
		int              fails;
		tx_result_t      expected_q[$];

		function new();
			for (int i = 0; i < rrts_pkg::NODE_COUNT; i++) begin
				head[i] = 0;
				count[i] = 0;
				last_sent[i] = 0;
				err[i] = rrts_pkg::ERR_NONE;
				period[i] = 0;
			end
			pend_limit = 1000;
			ticks = 0;
			rr_ptr = 0;
			sent_mod = 0;
			fails = 0;
		endfunction

		function void write_reg(bit [2:0] idx, bit [31:0] value);
			if (idx == rrts_pkg::CFG_TIMEOUT)
				pend_limit = value;
			else if (idx < rrts_pkg::NODE_COUNT)
				period[idx] = value[15:0];
		endfunction

		function bit eligible(int unsigned n);
			bit [31:0] since;
			since = ticks - last_sent[n];
			return count[n] > 0 && since > {16'd0, period[n]};
		endfunction

		function void note_word(bit [2:0] kind, bit [1:0] nd, bit [10:0] id, bit [3:0] len,
				bit [63:0] pay, bit mbox, bit accepts);
			tx_result_t  r;
			int unsigned n, slot, k;
			bit [31:0]   since;
			r = '{default: 0};
			if (len > rrts_pkg::MAX_LEN)
				len = rrts_pkg::MAX_LEN;
			n = nd;
			case (kind)
				rrts_pkg::KIND_TICK: ticks++;
				rrts_pkg::KIND_ENQUEUE: if (err[n] == rrts_pkg::ERR_NONE) begin
					if (count[n] >= rrts_pkg::FRAME_SLOTS) begin
						err[n] = rrts_pkg::ERR_OVERRUN;
					end else begin
						slot = n * rrts_pkg::FRAME_SLOTS
							+ (head[n] + count[n]) % rrts_pkg::FRAME_SLOTS;
						slot_id[slot] = id;
						slot_len[slot] = len;
						slot_pay[slot] = (len >= rrts_pkg::MAX_LEN) ? pay :
							pay & ((64'd1 << (len * 8)) - 1);
						count[n]++;
					end
				end
				rrts_pkg::KIND_SEND: if (mbox) begin
					n = rr_ptr;
					for (k = 0; k < rrts_pkg::NODE_COUNT; k++) begin
						if (eligible(n))
							break;
						n = (n + 1) % rrts_pkg::NODE_COUNT;
					end
					if (k < rrts_pkg::NODE_COUNT) begin
						slot = n * rrts_pkg::FRAME_SLOTS + head[n];
						last_sent[n] = ticks;
						head[n] = (head[n] + 1) % rrts_pkg::FRAME_SLOTS;
						count[n]--;
						if (accepts) begin
							r.valid = 1;
							r.node = n;
							r.can_id = slot_id[slot];
							r.len = slot_len[slot];
							r.payload = slot_pay[slot];
							sent_mod = (sent_mod + 1) % 10;
							rr_ptr = (n + 1) % rrts_pkg::NODE_COUNT;
						end else begin
							err[n] = rrts_pkg::ERR_REFUSED;
						end
					end else begin
						n = nd;
					end
				end
				rrts_pkg::KIND_BUS_ERR:
					for (k = 0; k < rrts_pkg::NODE_COUNT; k++) err[k] = rrts_pkg::ERR_BUS;
				rrts_pkg::KIND_BUS_RST: for (k = 0; k < rrts_pkg::NODE_COUNT; k++) begin
					err[k] = rrts_pkg::ERR_NONE;
					head[k] = 0;
					count[k] = 0;
				end
				rrts_pkg::KIND_TIMEOUT: begin
					since = ticks - last_sent[n];
					if (count[n] > 0 && since > pend_limit)
						err[n] = rrts_pkg::ERR_TIMEOUT;
				end
				default: ;
			endcase
			r.status = err[n];
			r.empty = (count[n] == 0);
			r.sent = sent_mod;
			expected_q.push_back(r);
		endfunction

		function void field(string name, bit [63:0] exp_v, bit [63:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
				fails++;
			end
		endfunction

		function void check_word(logic [95:0] d);
			tx_result_t e;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: 0x%0h", d);
				fails++;
				return;
			end
			e = expected_q.pop_front();
			field("frame_valid", e.valid, d[0]);
			field("frame_node", e.node, d[2:1]);
			field("frame_can_id", e.can_id, d[13:3]);
			field("frame_length", e.len, d[17:14]);
			field("frame_payload", e.payload, d[81:18]);
			field("node_status", e.status, d[84:82]);
			field("queue_empty", e.empty, d[85]);
			field("sent_count", e.sent, d[89:86]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;

	tx_scoreboard sb = new();
	int           snd_idle = 38;
	int           rcv_idle = 72;
	int           hold_left = 0;
	bit           held = 0;
	int           n_results = 0;
	int           cycles = 0;

	rate_limited_round_robin_tx_scheduler_unit u_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 500000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_word(m_axis_tdata);
			n_results++;
			if (n_results == 60 && !held) begin
				held = 1;
				hold_left = 300;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic put_word(bit [2:0] kind, bit [1:0] nd, bit [10:0] id, bit [3:0] len,
			bit [63:0] pay, bit mbox, bit accepts);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'd0, pay, len, id, nd, kind};
		s_axis_tuser <= {accepts, mbox};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_word(kind, nd, id, len, pay, mbox, accepts);
		while ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
	endtask

	task automatic rand_word();
		int        pick;
		bit [2:0]  kind;
		bit [3:0]  len;
		pick = $urandom_range(99);
		if (pick < 28)
			kind = rrts_pkg::KIND_TICK;
		else if (pick < 60)
			kind = rrts_pkg::KIND_ENQUEUE;
		else if (pick < 85)
			kind = rrts_pkg::KIND_SEND;
		else if (pick < 88)
			kind = rrts_pkg::KIND_BUS_ERR;
		else if (pick < 92)
			kind = rrts_pkg::KIND_BUS_RST;
		else if (pick < 98)
			kind = rrts_pkg::KIND_TIMEOUT;
		else
			kind = $urandom_range(7, 6);
		len = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
		put_word(kind, $urandom_range(3), $urandom_range(2047), len,
			{$urandom, $urandom}, $urandom_range(9) != 0, $urandom_range(7) != 0);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_regs(bit [15:0] p0, bit [15:0] p1, bit [15:0] p2, bit [15:0] p3,
			bit [31:0] tmo);
		bit [31:0] vals[5];
		vals = '{p0, p1, p2, p3, tmo};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			sb.write_reg(3'(i), vals[i]);
			@(posedge clk);
		end
		cfg_we <= 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		put_word(rrts_pkg::KIND_ENQUEUE, 0, 0, 0, '1, 1, 1);
		put_word(rrts_pkg::KIND_ENQUEUE, 0, 2047, 8, '1, 1, 1);
		put_word(rrts_pkg::KIND_ENQUEUE, 0, 1365, 15, '1, 1, 1);
		put_word(rrts_pkg::KIND_ENQUEUE, 0, 682, 3, '1, 1, 1);
		put_word(rrts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
		put_word(rrts_pkg::KIND_SEND, 0, 0, 0, 0, 0, 1);
		put_word(rrts_pkg::KIND_SEND, 0, 0, 0, 0, 1, 1);
		put_word(rrts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
		put_word(rrts_pkg::KIND_SEND, 0, 0, 0, 0, 1, 0);
		put_word(rrts_pkg::KIND_ENQUEUE, 0, 5, 2, '1, 1, 1);
		put_word(rrts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
		put_word(rrts_pkg::KIND_SEND, 3, 0, 0, 0, 1, 1);
		put_word(rrts_pkg::KIND_BUS_RST, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 9; i++)
			put_word(rrts_pkg::KIND_ENQUEUE, 1, 11'(i * 200), 4'(i),
				{$urandom, $urandom}, 1, 1);
		put_word(rrts_pkg::KIND_TIMEOUT, 1, 0, 0, 0, 0, 0);
		put_word(rrts_pkg::KIND_BUS_ERR, 2, 0, 0, 0, 0, 0);
		put_word(3'd6, 1, 0, 0, 0, 1, 1);
		put_word(3'd7, 1, 0, 0, 0, 1, 1);
		put_word(rrts_pkg::KIND_BUS_RST, 1, 0, 0, 0, 0, 0);
		repeat (150) rand_word();

		drain();
		write_regs(0, 3, 65535, 1, 0);
		snd_idle = 72;
		rcv_idle = 38;
		repeat (170) rand_word();

		drain();
		write_regs($urandom_range(4), 0, $urandom_range(6), 2, 20);
		snd_idle = 0;
		rcv_idle = 0;
		repeat (100) rand_word();

		drain();
		write_regs(1, 0, 0, 0, 32'hFFFF_FFFF);
		repeat (60) rand_word();

		drain();
		if (sb.fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

[files.f]
rtl/rrts_pkg.sv
rtl/rrts_datapath.sv
rtl/rrts_ctrl.sv
rtl/rate_limited_round_robin_tx_scheduler_unit.sv
bench/tb_top.sv
